@@ hdl/affr_pkg.sv @@
// Shared types, constants and command codes for the ADC frame resistance block.
`default_nettype none
package affr_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CHANNELS        = 5;
  localparam int CH_W            = 3;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  // channel positions in a frame
  localparam logic [CH_W-1:0] CH_PRIMARY   = 3'd0;
  localparam logic [CH_W-1:0] CH_VOLTAGE   = 3'd1;
  localparam logic [CH_W-1:0] CH_SECONDARY = 3'd2;

  localparam int UW     = 34;  // signed voltage / denominator width
  localparam int DIV_NW = 40;  // dividend width (u * 1000)
  localparam int DIV_DW = 33;  // divisor width (|den|)

  localparam logic [31:0] RECIP10  = 32'hCCCCCCCD;  // 2^35 / 10, rounded up
  localparam logic [31:0] RECIP100 = 32'h51EB851F;  // 2^37 / 100, rounded up
  localparam int RECIP10_SH  = 35;
  localparam int RECIP100_SH = 37;

  localparam logic [6:0] WEIGHT_FULL = 7'd100;
  localparam int CNT_MIN_U   = 3;
  localparam int CNT_MIN     = 10;
  localparam int LOW_THRESH  = 4000;
  localparam int HIGH_THRESH = 6000;
  localparam int R_LOW_MAX   = 6999;
  localparam int R_HIGH_MAX  = 299999;
  localparam int MV_MAX      = 27000000;
  localparam int MV_PER_V    = 1000;

  typedef enum logic [2:0] {
    REG_FILTER_WEIGHT  = 3'd0,
    REG_VOLT_GAIN      = 3'd1,
    REG_VOLT_OFFSET    = 3'd2,
    REG_CUR_GAIN_LOW   = 3'd3,
    REG_CUR_OFF_LOW    = 3'd4,
    REG_CUR_GAIN_HIGH  = 3'd5,
    REG_CUR_OFF_HIGH   = 3'd6,
    REG_OVERVOLT_LIMIT = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_FSUM, OP_FDIV, OP_PV, OP_QV, OP_PL, OP_QL, OP_PH, OP_QH,
    OP_PREP, OP_FIN
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FSUM, ST_FDIV, ST_PV, ST_QV, ST_PL, ST_QL, ST_PH, ST_QH,
    ST_PREP, ST_DIV, ST_FIN
  } state_t;

  typedef struct packed {
    logic            load;   // latch input beat
    op_t             op;
    logic [CH_W-1:0] ch;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage
`default_nettype wire

@@ hdl/affr_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module affr_div import affr_pkg::*; #(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic      [NW-1:0] quotient,
  output logic               done
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [NW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, quo[NW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

  assign quotient = quo;
  assign done     = !busy;
endmodule
`default_nettype wire

@@ hdl/affr_ctrl.sv @@
// Sequencer: steps the datapath through filter, calibration and division.
`default_nettype none
module affr_ctrl import affr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);
  state_t          state, state_next;
  logic [CH_W-1:0] ch, ch_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ch        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ch        <= ch_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = state != ST_IDLE;

  always_comb begin
    state_next     = state;
    ch_next        = ch;
    out_valid_next = out_valid && out_stall;
    cmd.load       = 1'b0;
    cmd.op         = OP_NONE;
    cmd.ch         = ch;
    case (state)
      ST_IDLE: begin
        ch_next = '0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_FSUM;
        end
      end
      ST_FSUM: begin
        cmd.op     = OP_FSUM;
        state_next = ST_FDIV;
      end
      ST_FDIV: begin
        cmd.op = OP_FDIV;
        if (ch == CH_LAST) begin
          state_next = ST_PV;
        end else begin
          ch_next    = ch + 1'b1;
          state_next = ST_FSUM;
        end
      end
      ST_PV: begin cmd.op = OP_PV; state_next = ST_QV; end
      ST_QV: begin cmd.op = OP_QV; state_next = ST_PL; end
      ST_PL: begin cmd.op = OP_PL; state_next = ST_QL; end
      ST_QL: begin cmd.op = OP_QL; state_next = ST_PH; end
      ST_PH: begin cmd.op = OP_PH; state_next = ST_QH; end
      ST_QH: begin cmd.op = OP_QH; state_next = ST_PREP; end
      ST_PREP: begin
        cmd.op     = OP_PREP;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.op         = OP_FIN;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/affr_datapath.sv @@
// Datapath: config registers, filters, shared multiplier, dividers, result register.
`default_nettype none
module affr_datapath import affr_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ctrl_cmd_t              cmd,
  output dp_status_t                  status,
  input  wire logic                   cfg_write,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [15:0]            cfg_data,
  input  wire logic [SAMPLE_BITS-1:0] sample_primary,
  input  wire logic [SAMPLE_BITS-1:0] sample_voltage,
  input  wire logic [SAMPLE_BITS-1:0] sample_secondary,
  input  wire logic [SAMPLE_BITS-1:0] sample_battery,
  input  wire logic [SAMPLE_BITS-1:0] sample_zero_wire,
  input  wire logic                   first_frame,
  output logic [12:0]                 resistance_low_range,
  output logic [18:0]                 resistance_high_range,
  output logic [25:0]                 source_millivolts,
  output logic [SAMPLE_BITS-1:0]      filtered_primary,
  output logic [SAMPLE_BITS-1:0]      filtered_voltage,
  output logic [SAMPLE_BITS-1:0]      filtered_secondary,
  output logic [SAMPLE_BITS-1:0]      filtered_battery,
  output logic [SAMPLE_BITS-1:0]      filtered_zero_wire,
  output logic                        overvolt_trip
);
  localparam int SW   = SAMPLE_BITS;
  localparam int SUMW = SW + 7;

  // configuration
  logic [6:0]         filter_weight;
  logic [15:0]        volt_gain, cur_gain_low, cur_gain_high, overvolt_limit;
  logic signed [15:0] volt_offset, cur_off_low, cur_off_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_weight  <= WEIGHT_FULL;
      volt_gain      <= 16'd10;
      volt_offset    <= '0;
      cur_gain_low   <= 16'd10;
      cur_off_low    <= '0;
      cur_gain_high  <= 16'd10;
      cur_off_high   <= '0;
      overvolt_limit <= 16'hFFFF;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FILTER_WEIGHT:  filter_weight  <= cfg_data[6:0];
        REG_VOLT_GAIN:      volt_gain      <= cfg_data;
        REG_VOLT_OFFSET:    volt_offset    <= cfg_data;
        REG_CUR_GAIN_LOW:   cur_gain_low   <= cfg_data;
        REG_CUR_OFF_LOW:    cur_off_low    <= cfg_data;
        REG_CUR_GAIN_HIGH:  cur_gain_high  <= cfg_data;
        REG_CUR_OFF_HIGH:   cur_off_high   <= cfg_data;
        REG_OVERVOLT_LIMIT: overvolt_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input beat and filter state
  logic [SW-1:0] samp [CHANNELS];
  logic [SW-1:0] filt [CHANNELS];
  logic          start_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp[0] <= sample_primary;
      samp[1] <= sample_voltage;
      samp[2] <= sample_secondary;
      samp[3] <= sample_battery;
      samp[4] <= sample_zero_wire;
      start_r <= first_frame;
    end
  end

  // start of measurement: weight 100 loads the raw sample exactly
  logic [6:0]      k_eff;
  logic [SUMW-1:0] fsum;
  logic [SUMW:0]   fsum_next;

  always_comb begin
    if (start_r || filter_weight > WEIGHT_FULL) k_eff = WEIGHT_FULL;
    else                                         k_eff = filter_weight;
    fsum_next = (SUMW+1)'(samp[cmd.ch]) * (SUMW+1)'(k_eff)
              + (SUMW+1)'(filt[cmd.ch]) * (SUMW+1)'(WEIGHT_FULL - k_eff);
  end

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_FDIV: begin mul_a = 32'(fsum);               mul_b = RECIP100; end
      OP_PV:   begin mul_a = 32'(filt[CH_VOLTAGE]);   mul_b = 32'(volt_gain); end
      OP_PL:   begin mul_a = 32'(filt[CH_PRIMARY]);   mul_b = 32'(cur_gain_low); end
      OP_PH:   begin mul_a = 32'(filt[CH_SECONDARY]); mul_b = 32'(cur_gain_high); end
      OP_QV, OP_QL, OP_QH: begin mul_a = prod[31:0]; mul_b = RECIP10; end
      default: ;
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  logic signed [UW-1:0] u, den_l, den_h, q10;
  assign q10 = $signed(UW'(mul_p[63:RECIP10_SH]));

  // flags and run state
  logic [1:0] ov_run;
  logic       trip;
  logic       zero_l, zero_h, max_l, max_h, neg_l, neg_h;

  logic [DIV_NW-1:0] num;
  logic [DIV_DW-1:0] dabs_l, dabs_h;
  logic [DIV_NW-1:0] quo_l, quo_h;
  logic              done_l, done_h;
  logic signed [UW-1:0] ov_level;
  logic       ov_hit;
  logic [1:0] run_base, run_new;
  logic       cu_low;

  assign num      = DIV_NW'(u[DIV_DW-1:0]) * DIV_NW'(MV_PER_V);
  assign dabs_l   = den_l[UW-1] ? DIV_DW'(-den_l) : den_l[DIV_DW-1:0];
  assign dabs_h   = den_h[UW-1] ? DIV_DW'(-den_h) : den_h[DIV_DW-1:0];
  // u/1000 > limit  <=>  u >= (limit+1)*1000
  assign ov_level = $signed((UW'(overvolt_limit) + UW'(1)) * UW'(MV_PER_V));
  assign ov_hit   = u >= ov_level;
  assign run_base = start_r ? 2'd0 : ov_run;
  assign run_new  = (run_base == 2'd3) ? 2'd3 : run_base + 2'd1;
  assign cu_low   = filt[CH_VOLTAGE] < SW'(CNT_MIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) filt[i] <= '0;
      ov_run <= '0;
      trip   <= 1'b0;
    end else begin
      if (cmd.op == OP_FDIV) filt[cmd.ch] <= mul_p[RECIP100_SH +: SW];
      if (cmd.op == OP_PREP) begin
        if (ov_hit) begin
          ov_run <= run_new;
          trip   <= (start_r ? 1'b0 : trip) || (run_new == 2'd3);
        end else begin
          ov_run <= '0;
          trip   <= start_r ? 1'b0 : trip;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_FSUM: fsum <= fsum_next[SUMW-1:0];
      OP_PV, OP_PL, OP_PH: prod <= mul_p;
      OP_QV: u <= (filt[CH_VOLTAGE] < SW'(CNT_MIN_U)) ? '0 : q10 + UW'(volt_offset);
      OP_QL: den_l <= q10 + UW'(cur_off_low);
      OP_QH: den_h <= q10 + UW'(cur_off_high);
      OP_PREP: begin
        zero_l <= cu_low || (u < UW'(LOW_THRESH));
        zero_h <= cu_low || (u < UW'(HIGH_THRESH));
        max_l  <= (filt[CH_PRIMARY] < SW'(CNT_MIN)) || (den_l == '0);
        max_h  <= (filt[CH_SECONDARY] < SW'(CNT_MIN)) || (den_h == '0);
        neg_l  <= den_l[UW-1];
        neg_h  <= den_h[UW-1];
      end
      default: ;
    endcase
  end

  affr_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_low (
    .clk, .rst, .start(cmd.op == OP_PREP), .dividend(num), .divisor(dabs_l),
    .quotient(quo_l), .done(done_l)
  );
  affr_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_high (
    .clk, .rst, .start(cmd.op == OP_PREP), .dividend(num), .divisor(dabs_h),
    .quotient(quo_h), .done(done_h)
  );
  assign status.div_done = done_l && done_h;

  // negative denominator: a nonzero quotient is negative and saturates,
  // a zero quotient stays zero
  logic [12:0] r_low;
  logic [18:0] r_high;
  always_comb begin
    if (zero_l)
      r_low = '0;
    else if (max_l || (neg_l && quo_l != '0) || quo_l > DIV_NW'(R_LOW_MAX))
      r_low = 13'(R_LOW_MAX);
    else
      r_low = quo_l[12:0];
    if (zero_h)
      r_high = '0;
    else if (max_h || (neg_h && quo_h != '0) || quo_h > DIV_NW'(R_HIGH_MAX))
      r_high = 19'(R_HIGH_MAX);
    else
      r_high = quo_h[18:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN) begin
      resistance_low_range  <= r_low;
      resistance_high_range <= r_high;
      source_millivolts     <= (u > UW'(MV_MAX)) ? 26'(MV_MAX) : u[25:0];
      filtered_primary      <= filt[0];
      filtered_voltage      <= filt[1];
      filtered_secondary    <= filt[2];
      filtered_battery      <= filt[3];
      filtered_zero_wire    <= filt[4];
      overvolt_trip         <= trip;
    end
  end
endmodule
`default_nettype wire

@@ hdl/adc_frame_filter_resistance_calc.sv @@
// Top level of the ADC frame filter and insulation resistance calculator.
//
// Input channel: one beat is a frame of five ADC samples plus first_frame,
// taken when in_valid is high and in_stall low. in_stall is high while a
// frame is in work, so frames are processed one at a time.
// Output channel: one beat per frame, held in an output register with
// out_valid until out_stall is low. A new frame is taken while a finished
// result still waits; the block only stalls at its last step if the
// previous result has not left yet.
// Steps from accepted frame to out_valid: the five filter channels (sum,
// then reciprocal multiply by 1/100) on one shared multiplier, the
// voltage and two current calibrations, a setup step, the two
// resistance divisions (bit-serial dividers running in parallel, 40-bit
// dividend), and the load of the output register. A new frame is taken
// only once the sequencer is back in its idle state after that load.
// Reset (rst, synchronous): filters, run counter and trip flag clear,
// config registers take their defaults, no beat is pending.
// Config writes (cfg_write, cfg_index, cfg_data) take effect at once;
// write them only while no frame is in work.
`default_nettype none
module adc_frame_filter_resistance_calc import affr_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [15:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] sample_primary,
  input  wire logic [SAMPLE_BITS-1:0] sample_voltage,
  input  wire logic [SAMPLE_BITS-1:0] sample_secondary,
  input  wire logic [SAMPLE_BITS-1:0] sample_battery,
  input  wire logic [SAMPLE_BITS-1:0] sample_zero_wire,
  input  wire logic                   first_frame,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [12:0]                 resistance_low_range,
  output logic [18:0]                 resistance_high_range,
  output logic [25:0]                 source_millivolts,
  output logic [SAMPLE_BITS-1:0]      filtered_primary,
  output logic [SAMPLE_BITS-1:0]      filtered_voltage,
  output logic [SAMPLE_BITS-1:0]      filtered_secondary,
  output logic [SAMPLE_BITS-1:0]      filtered_battery,
  output logic [SAMPLE_BITS-1:0]      filtered_zero_wire,
  output logic                        overvolt_trip
);
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  affr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status, .cmd
  );

  // arithmetic and state
  affr_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst, .cmd, .status,
    .cfg_write, .cfg_index, .cfg_data,
    .sample_primary, .sample_voltage, .sample_secondary, .sample_battery,
    .sample_zero_wire, .first_frame,
    .resistance_low_range, .resistance_high_range, .source_millivolts,
    .filtered_primary, .filtered_voltage, .filtered_secondary,
    .filtered_battery, .filtered_zero_wire, .overvolt_trip
  );
endmodule
`default_nettype wire

@@ hdl/affr_checker.sv @@
// Port-level checks for the resistance calculator, bound to the top level.
`default_nettype none
module affr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [12:0] resistance_low_range,
  input wire logic [18:0] resistance_high_range,
  input wire logic [25:0] source_millivolts
);
  // one frame in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("frame accepted while previous still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(source_millivolts)))
    else $error("stalled result beat changed");

  a_res_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (resistance_low_range <= 13'd6999 &&
                   resistance_high_range <= 19'd299999))
    else $error("resistance beyond saturation limit");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");
endmodule

bind adc_frame_filter_resistance_calc affr_checker u_affr_checker (.*);
`default_nettype wire

@@ test/tb_adc_frame_filter_resistance_calc.sv @@
// Testbench for the ADC frame filter and insulation resistance calculator.
`timescale 1ns / 1ps
module tb_adc_frame_filter_resistance_calc;
  import affr_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 70;   // longer than one frame takes through the block
  localparam int PHASES       = 10;
  localparam int PHASE_FRAMES = 145;

  typedef struct packed {
    logic [12:0]      r_lo;
    logic [18:0]      r_hi;
    logic [25:0]      mv;
    logic [4:0][11:0] filt;
    logic             trip;
  } frame_result_t;

  // one line of the directed table: a register write or a frame
  typedef struct packed {
    logic             is_cfg;
    cfg_reg_t         idx;
    logic [15:0]      data;
    logic             start;
    logic [4:0][11:0] smp;
    logic             typed;     // expected result written in the table
    frame_result_t    res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] sample_primary = '0, sample_voltage = '0, sample_secondary = '0;
  logic [11:0] sample_battery = '0, sample_zero_wire = '0;
  logic        first_frame = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [12:0] resistance_low_range;
  logic [18:0] resistance_high_range;
  logic [25:0] source_millivolts;
  logic [11:0] filtered_primary, filtered_voltage, filtered_secondary;
  logic [11:0] filtered_battery, filtered_zero_wire;
  logic        overvolt_trip;

  adc_frame_filter_resistance_calc i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall,
    .sample_primary, .sample_voltage, .sample_secondary,
    .sample_battery, .sample_zero_wire, .first_frame,
    .out_valid, .out_stall,
    .resistance_low_range, .resistance_high_range, .source_millivolts,
    .filtered_primary, .filtered_voltage, .filtered_secondary,
    .filtered_battery, .filtered_zero_wire, .overvolt_trip
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of the block's registers and state
  int unsigned weight_r;
  longint      vgain_r, voff_r, cgain_lo_r, coff_lo_r, cgain_hi_r, coff_hi_r, limit_r;
  logic [4:0][11:0] filt_st;
  int unsigned      run_st;
  logic             trip_st;

  frame_result_t expected_q[$];
  int            errors = 0;
  int            cycles = 0;
  int            out_beats = 0;
  bit            calm = 1'b0;     // no idling on either side
  bit            cfg_open = 1'b0;
  logic          cur_typed = 1'b0;
  frame_result_t cur_res = '0;

  // u*1000 over calibrated current, with the saturation rules
  function automatic longint resistance(longint cu, longint u, longint cr, longint gain,
                                        longint off, longint thresh, longint rmax);
    longint den, q;
    if (cu < 10 || u < thresh) return 0;
    if (cr < 10) return rmax;
    den = (cr * gain) / 10 + off;
    if (den == 0) return rmax;
    q = (u * 1000) / den;
    if (q > rmax || q < 0) return rmax;
    return q;
  endfunction

  // advance the predictor state by one frame and return its result
  function automatic frame_result_t predict_frame(logic [4:0][11:0] s, logic st);
    frame_result_t r;
    int unsigned   k;
    longint        u;
    k = (weight_r > 100) ? 100 : weight_r;
    for (int i = 0; i < CHANNELS; i++) begin
      if (st) filt_st[i] = s[i];
      else    filt_st[i] = 12'((int'(s[i]) * k + int'(filt_st[i]) * (100 - k)) / 100);
    end
    if (st) begin
      run_st  = 0;
      trip_st = 1'b0;
    end
    u = (filt_st[1] < 3) ? 0 : (longint'(filt_st[1]) * vgain_r) / 10 + voff_r;
    r.r_lo = 13'(resistance(filt_st[1], u, filt_st[0], cgain_lo_r, coff_lo_r,
                            LOW_THRESH, R_LOW_MAX));
    r.r_hi = 19'(resistance(filt_st[1], u, filt_st[2], cgain_hi_r, coff_hi_r,
                            HIGH_THRESH, R_HIGH_MAX));
    if (u / 1000 > limit_r) begin
      if (run_st < 3) run_st++;
      if (run_st >= 3) trip_st = 1'b1;
    end else begin
      run_st = 0;
    end
    r.mv   = 26'((u > MV_MAX) ? MV_MAX : u);
    r.filt = filt_st;
    r.trip = trip_st;
    return r;
  endfunction

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      errors++;
      $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, e, a);
    end
  endtask

  // Monitor: both handshakes and config writes, sampled at the edge
  always @(posedge clk) begin
    frame_result_t e, p;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_FILTER_WEIGHT:  weight_r   = cfg_data[6:0];
          REG_VOLT_GAIN:      vgain_r    = cfg_data;
          REG_VOLT_OFFSET:    voff_r     = longint'($signed(cfg_data));
          REG_CUR_GAIN_LOW:   cgain_lo_r = cfg_data;
          REG_CUR_OFF_LOW:    coff_lo_r  = longint'($signed(cfg_data));
          REG_CUR_GAIN_HIGH:  cgain_hi_r = cfg_data;
          REG_CUR_OFF_HIGH:   coff_hi_r  = longint'($signed(cfg_data));
          REG_OVERVOLT_LIMIT: limit_r    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        p = predict_frame({sample_zero_wire, sample_battery, sample_secondary,
                           sample_voltage, sample_primary}, first_frame);
        expected_q.push_back(cur_typed ? cur_res : p);
      end
      if (out_valid && !out_stall) begin
        out_beats++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat: expected none actual r_lo %0d",
                   $realtime, resistance_low_range);
        end else begin
          e = expected_q.pop_front();
          check_field("resistance_low_range", e.r_lo, resistance_low_range);
          check_field("resistance_high_range", e.r_hi, resistance_high_range);
          check_field("source_millivolts", e.mv, source_millivolts);
          check_field("filtered_primary", e.filt[0], filtered_primary);
          check_field("filtered_voltage", e.filt[1], filtered_voltage);
          check_field("filtered_secondary", e.filt[2], filtered_secondary);
          check_field("filtered_battery", e.filt[3], filtered_battery);
          check_field("filtered_zero_wire", e.filt[4], filtered_zero_wire);
          check_field("overvolt_trip", e.trip, overvolt_trip);
        end
      end
    end
  end

  // Receiver: random stall before each beat, one long hold-off to back up the block
  initial begin
    int  n;
    bit  held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      n = calm ? 0 : $urandom_range(0, 18);
      if (!held && out_beats >= 300) begin
        held = 1'b1;
        n = 600;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic stim_row_t frame_row(logic st, int p, int v, int sc, int b, int z);
    stim_row_t r = '0;
    r.start = st;
    r.smp   = {12'(z), 12'(b), 12'(sc), 12'(v), 12'(p)};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(cfg_reg_t idx, logic [15:0] data);
    stim_row_t r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write strobe stays high across back-to-back writes, lowered by the next frame
  task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_open  = 1'b1;
    @(posedge clk);
  endtask

  task automatic send_frame(stim_row_t r);
    int gap;
    if (cfg_open) begin
      cfg_write <= 1'b0;
      cfg_open  = 1'b0;
    end
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_primary   <= r.smp[0];
    sample_voltage   <= r.smp[1];
    sample_secondary <= r.smp[2];
    sample_battery   <= r.smp[3];
    sample_zero_wire <= r.smp[4];
    first_frame      <= r.start;
    cur_typed        <= r.typed;
    cur_res          <= r.res;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic int rnd_sample();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15);
      1: return $urandom_range(4080, 4095);
      2: return $urandom_range(900, 2100);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic logic [15:0] rnd_gain();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(5, 40));
    endcase
  endfunction

  function automatic logic [15:0] rnd_offset();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  initial begin
    stim_row_t     table_q[$];
    stim_row_t     r;
    frame_result_t tr;
    bit            prev_cfg;

    // predictor state as after reset
    weight_r = 100; vgain_r = 10; voff_r = 0; cgain_lo_r = 10; coff_lo_r = 0;
    cgain_hi_r = 10; coff_hi_r = 0; limit_r = 65535;
    filt_st = '0; run_st = 0; trip_st = 1'b0;

    // directed table
    r = frame_row(1, 0, 0, 0, 0, 0);
    r.typed = 1'b1;                       // all zero: no current, no voltage
    table_q.push_back(r);
    r = frame_row(1, 4095, 4095, 4095, 4095, 4095);
    tr = '0;
    tr.r_lo = 13'd1000;                   // 4095 mV over 4095 units of current
    tr.mv   = 26'd4095;
    tr.filt = {5{12'd4095}};
    r.typed = 1'b1;
    r.res   = tr;
    table_q.push_back(r);
    table_q.push_back(frame_row(0, 0, 0, 0, 0, 0));
    table_q.push_back(cfg_row(REG_FILTER_WEIGHT, 16'd50));
    table_q.push_back(frame_row(0, 2000, 3000, 1000, 4095, 0));
    table_q.push_back(frame_row(0, 2000, 3000, 1000, 4095, 0));
    table_q.push_back(cfg_row(REG_FILTER_WEIGHT, 16'd127));   // weight above full
    table_q.push_back(frame_row(0, 1234, 2345, 3456, 4000, 55));
    table_q.push_back(cfg_row(REG_FILTER_WEIGHT, 16'd0));     // filters hold
    table_q.push_back(frame_row(0, 4095, 4095, 4095, 4095, 4095));
    table_q.push_back(cfg_row(REG_FILTER_WEIGHT, 16'd100));
    table_q.push_back(cfg_row(REG_VOLT_GAIN, 16'hFFFF));
    table_q.push_back(frame_row(1, 5, 4095, 5, 0, 0));        // small currents
    table_q.push_back(frame_row(1, 4095, 4095, 4095, 0, 0));  // huge quotients
    table_q.push_back(cfg_row(REG_VOLT_OFFSET, 16'h8000));
    table_q.push_back(frame_row(1, 100, 2, 100, 0, 0));       // count below 3
    table_q.push_back(cfg_row(REG_VOLT_GAIN, 16'd10));
    table_q.push_back(frame_row(1, 100, 100, 100, 0, 0));     // negative voltage
    table_q.push_back(cfg_row(REG_VOLT_OFFSET, 16'd0));
    table_q.push_back(cfg_row(REG_VOLT_GAIN, 16'd20));
    table_q.push_back(cfg_row(REG_CUR_OFF_LOW, 16'hFF9C));
    table_q.push_back(cfg_row(REG_CUR_OFF_HIGH, 16'hFF9C));
    table_q.push_back(frame_row(1, 100, 3000, 100, 0, 0));    // zero denominators
    table_q.push_back(cfg_row(REG_CUR_OFF_LOW, 16'h8000));
    table_q.push_back(cfg_row(REG_CUR_OFF_HIGH, 16'h7FFF));
    table_q.push_back(frame_row(1, 1000, 3000, 1000, 0, 0));  // negative quotient
    table_q.push_back(cfg_row(REG_CUR_GAIN_LOW, 16'd0));
    table_q.push_back(cfg_row(REG_CUR_GAIN_HIGH, 16'hFFFF));
    table_q.push_back(cfg_row(REG_CUR_OFF_LOW, 16'd0));
    table_q.push_back(cfg_row(REG_CUR_OFF_HIGH, 16'd0));
    table_q.push_back(frame_row(1, 1000, 3000, 4095, 0, 0));
    table_q.push_back(cfg_row(REG_CUR_GAIN_LOW, 16'd10));
    table_q.push_back(cfg_row(REG_CUR_GAIN_HIGH, 16'd10));
    table_q.push_back(cfg_row(REG_OVERVOLT_LIMIT, 16'd0));
    // over-voltage run: trips on the third, start clears, low voltage breaks the run
    table_q.push_back(frame_row(1, 500, 2000, 500, 0, 0));
    table_q.push_back(frame_row(0, 500, 2000, 500, 0, 0));
    table_q.push_back(frame_row(0, 500, 2000, 500, 0, 0));
    table_q.push_back(frame_row(0, 500, 2000, 500, 0, 0));
    table_q.push_back(frame_row(1, 500, 2000, 500, 0, 0));
    table_q.push_back(frame_row(0, 500, 200, 500, 0, 0));
    table_q.push_back(frame_row(0, 500, 2000, 500, 0, 0));
    table_q.push_back(cfg_row(REG_OVERVOLT_LIMIT, 16'hFFFF));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    prev_cfg = 1'b0;
    foreach (table_q[i]) begin
      if (table_q[i].is_cfg) begin
        if (!prev_cfg) begin
          in_valid <= 1'b0;
          wait_idle();
        end
        write_reg(table_q[i].idx, table_q[i].data);
      end else begin
        send_frame(table_q[i]);
      end
      prev_cfg = table_q[i].is_cfg;
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid <= 1'b0;
      wait_idle();
      case ($urandom_range(0, 4))
        0: write_reg(REG_FILTER_WEIGHT, 16'd0);
        1: write_reg(REG_FILTER_WEIGHT, 16'd100);
        2: write_reg(REG_FILTER_WEIGHT, 16'd127);
        3: write_reg(REG_FILTER_WEIGHT, 16'($urandom_range(0, 127)));
        default: write_reg(REG_FILTER_WEIGHT, 16'($urandom_range(1, 99)));
      endcase
      write_reg(REG_VOLT_GAIN, rnd_gain());
      write_reg(REG_VOLT_OFFSET, rnd_offset());
      write_reg(REG_CUR_GAIN_LOW, rnd_gain());
      write_reg(REG_CUR_OFF_LOW, rnd_offset());
      write_reg(REG_CUR_GAIN_HIGH, rnd_gain());
      write_reg(REG_CUR_OFF_HIGH, rnd_offset());
      case ($urandom_range(0, 3))
        0: write_reg(REG_OVERVOLT_LIMIT, 16'd0);
        1: write_reg(REG_OVERVOLT_LIMIT, 16'hFFFF);
        2: write_reg(REG_OVERVOLT_LIMIT, 16'($urandom_range(0, 30)));
        default: write_reg(REG_OVERVOLT_LIMIT, 16'($urandom_range(0, 65535)));
      endcase
      calm = (ph % 4 == 1);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        r = frame_row(n == 0 || $urandom_range(0, 24) == 0, rnd_sample(), rnd_sample(),
                      rnd_sample(), rnd_sample(), rnd_sample());
        send_frame(r);
      end
      calm = 1'b0;
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/affr_pkg.sv
hdl/affr_div.sv
hdl/affr_ctrl.sv
hdl/affr_datapath.sv
hdl/adc_frame_filter_resistance_calc.sv
hdl/affr_checker.sv
test/tb_adc_frame_filter_resistance_calc.sv
